// ----- sv/nearest_palette_colour_match_defines.svh -----
// assertion macros shared by the palette matcher modules
// no dependencies; included by the controller and the datapath
`ifndef NEAREST_PALETTE_COLOUR_MATCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOUR_MATCH_DEFINES_SVH

`ifndef SYNTH
`define NPCM_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define NPCM_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define NPCM_ASSERT_SAME(label, clk, rst, pre, post)
`define NPCM_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ----- sv/npcm_pkg.sv -----
// shared types, widths and the 5-to-8 bit widening table for the palette matcher
// no dependencies; used by npcm_ctrl, npcm_datapath and the top level
`default_nettype none

package npcm_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int SIZE_W        = 9;
  localparam int LEVEL_W       = 8;
  localparam int ENTRY_W       = 3 * LEVEL_W;
  localparam int SQ_W          = 2 * LEVEL_W;
  localparam int DIST_W        = 19;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
  localparam logic [DIST_W-1:0] NO_MATCH   = 19'h7ffff;
  localparam logic [DIST_W-1:0] MAX_DIST   = 19'd455175;

  localparam logic action_load  = 1'b0;
  localparam logic action_match = 1'b1;

  // floor(v * 255 / 31) for every 5-bit channel value
  localparam logic [LEVEL_W-1:0] WIDEN5_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  function automatic logic [LEVEL_W-1:0] widen5(input logic [4:0] v);
    return WIDEN5_LUT[v];
  endfunction

  typedef struct packed {
    logic             load_we;
    logic             start;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             out_load;
  } npcm_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } npcm_stat_t;

endpackage

`default_nettype wire

// ----- sv/nearest_palette_colour_match.sv -----
// nearest palette match: a palette of 8-bit rgb entries searched for the
// entry closest to an rgb555 pixel under 2*dr^2 + 4*dg^2 + db^2.
// input channel: in_valid/in_stall; a word with action 0 loads entry
//   entry_index with red/green/blue_level, action 1 matches pixel_rgb555.
// output channel: out_valid/out_stall, one word (best_index, best_distance)
//   per match word, none per load word; ties go to the lowest index.
// config channel: cfg_valid/cfg_ready (ready always high) writes palette_size,
//   the number of entries searched from entry zero; reset value 256.
// loads: one load word per cycle, while no match is in progress.
// a match over N > 0 entries (N = palette_size, clipped to 256) reads one
//   entry per cycle through the single palette read port into one distance
//   unit, drains the distance pipeline, then loads the output register; the
//   next word is taken only once the result has been loaded.
// palette_size 0 gives best_index 0 and best_distance 0x7ffff without a scan.
// the result sits in an output register; while the receiver stalls the
//   block still takes load words if no match is pending; a finished match
//   waits until the register is free, with in_stall high meanwhile.
// reset (rst, synchronous) clears control state and sets palette_size to 256;
//   palette contents are not cleared and must be loaded before a match.
`default_nettype none

module nearest_palette_colour_match (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        action,
  input  wire logic [7:0]                  entry_index,
  input  wire logic [7:0]                  red_level,
  input  wire logic [7:0]                  green_level,
  input  wire logic [7:0]                  blue_level,
  input  wire logic [14:0]                 pixel_rgb555,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       best_index,
  output logic [npcm_pkg::DIST_W-1:0]      best_distance,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [npcm_pkg::SIZE_W-1:0] palette_size
);

  npcm_pkg::npcm_cmd_t  cmd;
  npcm_pkg::npcm_stat_t stat;

  npcm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .entry_index  (entry_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .palette_size (palette_size),
    .cmd          (cmd),
    .stat         (stat)
  );

  npcm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .entry_index   (entry_index),
    .red_level     (red_level),
    .green_level   (green_level),
    .blue_level    (blue_level),
    .pixel_rgb555  (pixel_rgb555),
    .best_index    (best_index),
    .best_distance (best_distance)
  );

endmodule

`default_nettype wire

// ----- sv/npcm_ctrl.sv -----
// controller: handshakes, size register and the scan sequencer
// depends on npcm_pkg and the defines header; drives npcm_datapath
`default_nettype none
`include "nearest_palette_colour_match_defines.svh"

module npcm_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        action,
  input  wire logic [7:0]                  entry_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [npcm_pkg::SIZE_W-1:0] palette_size,
  output npcm_pkg::npcm_cmd_t              cmd,
  input  wire npcm_pkg::npcm_stat_t        stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_OUT
  } state_t;

  state_t                         state;
  logic [npcm_pkg::SIZE_W-1:0]    search_size;
  logic [npcm_pkg::IDX_W-1:0]     addr;
  logic [npcm_pkg::IDX_W-1:0]     last_addr;
  logic [npcm_pkg::CNT_W-1:0]     count_clip;
  logic                           in_accept;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  // search never goes past the physical palette
  assign count_clip = (search_size > npcm_pkg::SIZE_W'(npcm_pkg::PALETTE_DEPTH))
                    ? npcm_pkg::CNT_W'(npcm_pkg::PALETTE_DEPTH)
                    : npcm_pkg::CNT_W'(search_size);

  always_comb begin
    cmd.load_we  = in_accept && (action == npcm_pkg::action_load) &&
                   (9'(entry_index) < 9'(npcm_pkg::PALETTE_DEPTH));
    cmd.start    = in_accept && (action == npcm_pkg::action_match);
    cmd.rd_en    = (state == S_SCAN);
    cmd.rd_addr  = addr;
    cmd.out_load = (state == S_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      search_size <= npcm_pkg::SIZE_RESET;
      addr        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        search_size <= palette_size;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            addr      <= '0;
            last_addr <= npcm_pkg::IDX_W'(count_clip - npcm_pkg::CNT_W'(1));
            state     <= (count_clip == '0) ? S_OUT : S_SCAN;
          end
        end
        S_SCAN: begin
          addr <= addr + npcm_pkg::IDX_W'(1);
          if (addr == last_addr) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          // wait for the last entry to leave the distance pipeline
          if (!stat.pipe_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `NPCM_ASSERT_SAME(a_out_pipe_empty, clk, rst, state == S_OUT, !stat.pipe_busy)
  `NPCM_ASSERT_NEXT(a_start_leaves_idle, clk, rst, cmd.start,
                    state == S_SCAN || state == S_OUT)
  `NPCM_ASSERT_NEXT(a_flush_done, clk, rst, state == S_FLUSH && !stat.pipe_busy,
                    state == S_OUT)

endmodule

`default_nettype wire

// ----- sv/npcm_datapath.sv -----
// datapath: palette memory, distance pipeline, running minimum and result register
// depends on npcm_pkg and the defines header; commanded by npcm_ctrl
`default_nettype none
`include "nearest_palette_colour_match_defines.svh"

module npcm_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire npcm_pkg::npcm_cmd_t          cmd,
  output npcm_pkg::npcm_stat_t              stat,
  input  wire logic [7:0]                   entry_index,
  input  wire logic [7:0]                   red_level,
  input  wire logic [7:0]                   green_level,
  input  wire logic [7:0]                   blue_level,
  input  wire logic [14:0]                  pixel_rgb555,
  output logic [7:0]                        best_index,
  output logic [npcm_pkg::DIST_W-1:0]       best_distance
);

  logic [npcm_pkg::ENTRY_W-1:0] palette [npcm_pkg::PALETTE_DEPTH];
  logic [npcm_pkg::ENTRY_W-1:0] rd_data;

  logic [npcm_pkg::LEVEL_W-1:0] pix_r;
  logic [npcm_pkg::LEVEL_W-1:0] pix_g;
  logic [npcm_pkg::LEVEL_W-1:0] pix_b;

  logic                         v1;
  logic                         v2;
  logic [npcm_pkg::IDX_W-1:0]   idx1;
  logic [npcm_pkg::IDX_W-1:0]   idx2;

  logic [npcm_pkg::LEVEL_W-1:0] d_r;
  logic [npcm_pkg::LEVEL_W-1:0] d_g;
  logic [npcm_pkg::LEVEL_W-1:0] d_b;
  logic [npcm_pkg::SQ_W-1:0]    sq_r;
  logic [npcm_pkg::SQ_W-1:0]    sq_g;
  logic [npcm_pkg::SQ_W-1:0]    sq_b;
  logic [npcm_pkg::DIST_W-1:0]  entry_distance;

  logic [npcm_pkg::IDX_W-1:0]   best_idx;
  logic [npcm_pkg::DIST_W-1:0]  best_dist;

  // entry layout: red 7..0, green 15..8, blue 23..16
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      palette[entry_index[npcm_pkg::IDX_W-1:0]] <= {blue_level, green_level, red_level};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= palette[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pix_r <= npcm_pkg::widen5(pixel_rgb555[4:0]);
      pix_g <= npcm_pkg::widen5(pixel_rgb555[9:5]);
      pix_b <= npcm_pkg::widen5(pixel_rgb555[14:10]);
    end
  end

  always_comb begin
    d_r = (rd_data[7:0]   > pix_r) ? rd_data[7:0]   - pix_r : pix_r - rd_data[7:0];
    d_g = (rd_data[15:8]  > pix_g) ? rd_data[15:8]  - pix_g : pix_g - rd_data[15:8];
    d_b = (rd_data[23:16] > pix_b) ? rd_data[23:16] - pix_b : pix_b - rd_data[23:16];
  end

  assign entry_distance = npcm_pkg::DIST_W'({sq_r, 1'b0}) + npcm_pkg::DIST_W'({sq_g, 2'b00})
                        + npcm_pkg::DIST_W'(sq_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= cmd.rd_addr;
    idx2 <= idx1;
    sq_r <= npcm_pkg::SQ_W'(d_r) * npcm_pkg::SQ_W'(d_r);
    sq_g <= npcm_pkg::SQ_W'(d_g) * npcm_pkg::SQ_W'(d_g);
    sq_b <= npcm_pkg::SQ_W'(d_b) * npcm_pkg::SQ_W'(d_b);
  end

  // strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_idx  <= '0;
      best_dist <= npcm_pkg::NO_MATCH;
    end else if (v2 && (entry_distance < best_dist)) begin
      best_idx  <= idx2;
      best_dist <= entry_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      best_index    <= 8'(best_idx);
      best_distance <= best_dist;
    end
  end

  assign stat.pipe_busy = v1 | v2;

  `NPCM_ASSERT_SAME(a_dist_in_range, clk, rst, v2, entry_distance <= npcm_pkg::MAX_DIST)

endmodule

`default_nettype wire
